/* design/lsf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the Laplacian / sharpen 3x3 filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;
    localparam int ACC_W   = 12;
    localparam int LINE_W  = 2 * PIX_W;

    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_KERNEL_SELECT = 2'd2;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd5;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd4;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_col;
        logic last_row;
    } pos_flags_t;

endpackage
`default_nettype wire

/* design/lsf_line_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_line_mem
// Line store: one word per column holding rows r-1 and r-2, registered read
// with write-to-read forwarding on the same address.
// ----------------------------------------------------------------------------
module lsf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [lsf_pkg::LINE_W-1:0] wr_data,
    input  wire logic                      re,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [lsf_pkg::LINE_W-1:0] rd_data
);

    logic [lsf_pkg::LINE_W-1:0] mem [DEPTH];
    logic [lsf_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* design/lsf_pos_ctr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_pos_ctr
// Raster position counters with effective frame size and border flags.
// ----------------------------------------------------------------------------
module lsf_pos_ctr #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = $clog2(MAX_WIDTH),
    parameter int RW         = $clog2(MAX_HEIGHT)
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [lsf_pkg::CFG_W-1:0] frame_width,
    input  wire logic [lsf_pkg::CFG_W-1:0] frame_height,
    input  wire logic                     restart,
    input  wire logic                     advance,
    output logic      [CW-1:0]            col,
    output logic      [RW-1:0]            row,
    output lsf_pkg::pos_flags_t           flags
);

    localparam int CEW = CW + 1;
    localparam int REW = RW + 1;
    localparam int CXW = (CEW > lsf_pkg::CFG_W) ? CEW : lsf_pkg::CFG_W;
    localparam int RXW = (REW > lsf_pkg::CFG_W) ? REW : lsf_pkg::CFG_W;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CXW-1:0] w_x;
    logic [RXW-1:0] h_x;
    logic [CEW-1:0] w_eff;
    logic [REW-1:0] h_eff;

    always_comb
    begin
        w_x = CXW'(frame_width);
        h_x = RXW'(frame_height);
        if (w_x == '0)
        begin
            w_x = CXW'(1);
        end
        else if (w_x > CXW'(MAX_WIDTH))
        begin
            w_x = CXW'(MAX_WIDTH);
        end
        if (h_x == '0)
        begin
            h_x = RXW'(1);
        end
        else if (h_x > RXW'(MAX_HEIGHT))
        begin
            h_x = RXW'(MAX_HEIGHT);
        end
        w_eff = CEW'(w_x);
        h_eff = REW'(h_x);
    end

    always_comb
    begin
        flags.row_ge1  = (row_reg != '0);
        flags.row_ge2  = (row_reg[RW-1:1] != '0);
        flags.col_ge1  = (col_reg != '0);
        flags.col_ge2  = (col_reg[CW-1:1] != '0);
        flags.last_col = ({1'b0, col_reg} == CEW'(w_eff - CEW'(1)));
        flags.last_row = ({1'b0, row_reg} == REW'(h_eff - REW'(1)));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (advance)
        begin
            if (flags.last_col)
            begin
                col_next = '0;
                row_next = flags.last_row ? '0 : RW'(row_reg + RW'(1));
            end
            else
            begin
                col_next = CW'(col_reg + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign col = col_reg;
    assign row = row_reg;

endmodule
`default_nettype wire

/* design/lsf_emit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_emit
// Filter stage: cross kernel over the window, result sequencing, line
// store write-back and the output register.
// ----------------------------------------------------------------------------
module lsf_emit #(
    parameter int CW = 10,
    parameter int RW = 10
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [lsf_pkg::PIX_W-1:0]   px,
    input  wire logic [RW-1:0]               row,
    input  wire logic [CW-1:0]               col,
    input  wire lsf_pkg::pos_flags_t         flags,
    input  wire logic                        kernel_sel,
    input  wire logic [lsf_pkg::LINE_W-1:0]  line_word,
    output logic                             can_load,
    output logic                             mem_we,
    output logic      [CW-1:0]               mem_addr,
    output logic      [lsf_pkg::LINE_W-1:0]  mem_wdata,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output logic      [lsf_pkg::COORD_W-1:0] out_row,
    output logic      [lsf_pkg::COORD_W-1:0] out_col,
    output logic      [lsf_pkg::PIX_W-1:0]   out_value,
    output logic                             run_last
);

    localparam int PW = lsf_pkg::PIX_W;
    localparam int AW = lsf_pkg::ACC_W;

    logic          s1_valid_reg;
    logic [2:0]    s1_mask_reg;
    logic [PW-1:0] s1_px_reg;
    logic [RW-1:0] s1_row_reg;
    logic [CW-1:0] s1_col_reg;
    logic          s1_int_reg;

    logic [PW-1:0] win_up_reg, win_cen_reg, win_dn_reg, win_left_reg;

    logic                      res_valid_reg;
    logic [lsf_pkg::COORD_W-1:0] res_row_reg, res_col_reg;
    logic [PW-1:0]             res_value_reg;
    logic                      res_last_reg;

    logic [PW-1:0] up1, up2;
    logic [AW-1:0] acc;
    logic [PW-1:0] filt;
    logic [2:0]    sel, mask_after;
    logic          out_load, emit_now, retire;
    logic [RW-1:0] row_m1;
    logic [CW-1:0] col_m1;
    logic [RW-1:0] sel_row;
    logic [CW-1:0] sel_col;
    logic [PW-1:0] sel_value;

    assign up1 = line_word[PW-1:0];
    assign up2 = line_word[2*PW-1:PW];

    always_comb
    begin
        acc = {2'b00, win_cen_reg, 2'b00}
            + (kernel_sel ? {4'b0000, win_cen_reg} : AW'(0))
            - {4'b0000, win_up_reg}
            - {4'b0000, win_left_reg}
            - {4'b0000, up1}
            - {4'b0000, win_dn_reg};
        if (acc[AW-1])
        begin
            filt = '0;
        end
        else if (acc[AW-2:PW] != '0)
        begin
            filt = '1;
        end
        else
        begin
            filt = acc[PW-1:0];
        end
    end

    always_comb
    begin
        sel = 3'b000;
        priority if (s1_mask_reg[0])
        begin
            sel = 3'b001;
        end
        else if (s1_mask_reg[1])
        begin
            sel = 3'b010;
        end
        else if (s1_mask_reg[2])
        begin
            sel = 3'b100;
        end
    end

    assign row_m1 = RW'(s1_row_reg - RW'(1));
    assign col_m1 = CW'(s1_col_reg - CW'(1));

    always_comb
    begin
        unique case (sel)
            3'b001:
            begin
                sel_row   = row_m1;
                sel_col   = col_m1;
                sel_value = s1_int_reg ? filt : win_cen_reg;
            end
            3'b010:
            begin
                sel_row   = row_m1;
                sel_col   = s1_col_reg;
                sel_value = up1;
            end
            default:
            begin
                sel_row   = s1_row_reg;
                sel_col   = s1_col_reg;
                sel_value = s1_px_reg;
            end
        endcase
    end

    assign mask_after = s1_mask_reg & ~sel;
    assign out_load   = !res_valid_reg || res_ready;
    assign emit_now   = s1_valid_reg && (s1_mask_reg != 3'b000) && out_load;
    assign retire     = s1_valid_reg
                      && ((s1_mask_reg == 3'b000) || (emit_now && (mask_after == 3'b000)));
    assign can_load   = !s1_valid_reg || retire;

    assign mem_we    = retire;
    assign mem_addr  = s1_col_reg;
    assign mem_wdata = {up1, s1_px_reg};

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= 3'b000;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
            s1_mask_reg  <= {flags.last_row,
                             flags.row_ge1 && flags.last_col,
                             flags.row_ge1 && flags.col_ge1};
        end
        else if (retire)
        begin
            s1_valid_reg <= 1'b0;
            s1_mask_reg  <= 3'b000;
        end
        else if (emit_now)
        begin
            s1_mask_reg <= mask_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_px_reg  <= px;
            s1_row_reg <= row;
            s1_col_reg <= col;
            s1_int_reg <= flags.row_ge2 && flags.col_ge2;
        end
    end

    // shift the window on retire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg   <= '0;
            win_cen_reg  <= '0;
            win_dn_reg   <= '0;
            win_left_reg <= '0;
        end
        else if (retire)
        begin
            win_up_reg   <= up2;
            win_cen_reg  <= up1;
            win_dn_reg   <= s1_px_reg;
            win_left_reg <= win_cen_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit_now)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_now)
        begin
            res_row_reg   <= lsf_pkg::COORD_W'(sel_row);
            res_col_reg   <= lsf_pkg::COORD_W'(sel_col);
            res_value_reg <= sel_value;
            res_last_reg  <= (mask_after == 3'b000);
        end
    end

    assign res_valid = res_valid_reg;
    assign out_row   = res_row_reg;
    assign out_col   = res_col_reg;
    assign out_value = res_value_reg;
    assign run_last  = res_last_reg;

endmodule
`default_nettype wire

/* design/laplacian_sharpen_3x3_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_filter
// 4-neighbour cross filter (Laplacian or sharpen) over a raster pixel
// stream, borders passed through, results tagged with row and column.
//
//   channel   handshake               payload
//   pixel     pix_valid / pix_ready   pixel_in
//   result    res_valid / res_ready   out_row, out_col, out_value, run_last
//   config    cfg_we                  cfg_index, cfg_data
//
// One pixel per cycle while pix_ready is high: the line store is read when a word
// is accepted and written back when the filter stage retires it; the first result
// of a pixel passes the filter stage register and then the output register. A
// pixel yields 0 to 3 results, one per cycle unless res_ready stalls the output
// register; pixels that yield 2 or 3 (row/frame ends) hold input until the last.
// Reset clears counters, window and control; the line store is not cleared.
// A stalled result holds the filter stage, which then holds pix_ready low.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pix_valid,
    output logic                              pix_ready,
    input  wire logic [lsf_pkg::PIX_W-1:0]    pixel_in,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic      [lsf_pkg::COORD_W-1:0]  out_row,
    output logic      [lsf_pkg::COORD_W-1:0]  out_col,
    output logic      [lsf_pkg::PIX_W-1:0]    out_value,
    output logic                              run_last,
    input  wire logic                         cfg_we,
    input  wire logic [lsf_pkg::CIDX_W-1:0]   cfg_index,
    input  wire logic [lsf_pkg::CFG_W-1:0]    cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [lsf_pkg::CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [lsf_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;
    logic                      kernel_select_reg, kernel_select_next;
    logic                      size_wr;

    logic                      pix_fire;
    logic [CW-1:0]             col;
    logic [RW-1:0]             row;
    lsf_pkg::pos_flags_t       flags;
    logic [lsf_pkg::LINE_W-1:0] line_word;
    logic                      mem_we;
    logic [CW-1:0]             mem_addr;
    logic [lsf_pkg::LINE_W-1:0] mem_wdata;
    logic                      can_load;

    always_comb
    begin
        frame_width_next   = frame_width_reg;
        frame_height_next  = frame_height_reg;
        kernel_select_next = kernel_select_reg;
        size_wr            = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lsf_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data;
                    size_wr          = 1'b1;
                end
                lsf_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data;
                    size_wr           = 1'b1;
                end
                lsf_pkg::CFG_KERNEL_SELECT:
                begin
                    kernel_select_next = cfg_data[0];
                end
                default:
                begin
                    // drop unknown index
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= lsf_pkg::RST_FRAME_WIDTH;
            frame_height_reg  <= lsf_pkg::RST_FRAME_HEIGHT;
            kernel_select_reg <= 1'b0;
        end
        else
        begin
            frame_width_reg   <= frame_width_next;
            frame_height_reg  <= frame_height_next;
            kernel_select_reg <= kernel_select_next;
        end
    end

    assign pix_ready = can_load;
    assign pix_fire  = pix_valid && can_load;

    lsf_pos_ctr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .restart      (size_wr),
        .advance      (pix_fire),
        .col          (col),
        .row          (row),
        .flags        (flags)
    );

    lsf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_mem (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_addr),
        .wr_data (mem_wdata),
        .re      (pix_fire),
        .rd_addr (col),
        .rd_data (line_word)
    );

    lsf_emit #(
        .CW (CW),
        .RW (RW)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (pix_fire),
        .px         (pixel_in),
        .row        (row),
        .col        (col),
        .flags      (flags),
        .kernel_sel (kernel_select_reg),
        .line_word  (line_word),
        .can_load   (can_load),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_row    (out_row),
        .out_col    (out_col),
        .out_value  (out_value),
        .run_last   (run_last)
    );

`ifndef ASSERT_OFF
    a_size_restart: assert property (@(posedge clk) disable iff (!rst_n)
        size_wr |=> (col == '0) && (row == '0))
        else $error("position not restarted after size write");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && !size_wr && flags.last_col |=> (col == '0))
        else $error("column did not wrap at row end");

    a_wb_frees: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> pix_ready)
        else $error("line store written back while filter stage held");
`endif

endmodule
`default_nettype wire

/* dv/laplacian_sharpen_3x3_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_filter_test
// Drives raster pixel streams through the cross filter under random idling on
// both channels and compares each tagged result word with a local model of
// the line store, window and position counters. Covers both kernels, clamping
// at either end, 1- and 2-wide/high frames, zero and oversize register values,
// frame restart on size writes, the unused register index and partial frames.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_filter_test;

    localparam int MAX_SIDE    = 1024;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 20;

    localparam logic [lsf_pkg::CIDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int SMALL_W [8] = '{0, 1, 2, 1, 2, 3, 2, 3};
    localparam int SMALL_H [8] = '{0, 1, 1, 2, 2, 2, 3, 3};

    typedef struct packed {
        logic [lsf_pkg::COORD_W-1:0] row;
        logic [lsf_pkg::COORD_W-1:0] col;
        logic [lsf_pkg::PIX_W-1:0]   value;
        logic                        last;
    } pix_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          pix_valid;
    logic                          pix_ready;
    logic [lsf_pkg::PIX_W-1:0]     pixel_in;
    logic                          res_valid;
    logic                          res_ready;
    logic [lsf_pkg::COORD_W-1:0]   out_row;
    logic [lsf_pkg::COORD_W-1:0]   out_col;
    logic [lsf_pkg::PIX_W-1:0]     out_value;
    logic                          run_last;
    logic                          cfg_we;
    logic [lsf_pkg::CIDX_W-1:0]    cfg_index;
    logic [lsf_pkg::CFG_W-1:0]     cfg_data;

    // model state
    logic [lsf_pkg::PIX_W-1:0]     row_above [MAX_SIDE];
    logic [lsf_pkg::PIX_W-1:0]     row_above2 [MAX_SIDE];
    logic [lsf_pkg::PIX_W-1:0]     window [6];
    int unsigned                   row_pos;
    int unsigned                   col_pos;
    logic [lsf_pkg::CFG_W-1:0]     width_reg;
    logic [lsf_pkg::CFG_W-1:0]     height_reg;
    logic                          sharpen_reg;

    pix_result_t          pending_px [$];

    bit                   calm;
    int                   cycles;
    int                   faults;
    int                   pixels_sent;
    int                   results_seen;

    laplacian_sharpen_3x3_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pixel_in  (pixel_in),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .run_last  (run_last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned clip_size(input logic [lsf_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < MAX_SIDE; i++)
        begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            window[i] = '0;
        row_pos     = 0;
        col_pos     = 0;
        width_reg   = lsf_pkg::RST_FRAME_WIDTH;
        height_reg  = lsf_pkg::RST_FRAME_HEIGHT;
        sharpen_reg = 1'b0;
    endfunction

    function automatic void set_register(input logic [lsf_pkg::CIDX_W-1:0] idx,
                                         input logic [lsf_pkg::CFG_W-1:0] data);
        unique case (idx)
            lsf_pkg::CFG_FRAME_WIDTH:
            begin
                width_reg = data;
                row_pos   = 0;
                col_pos   = 0;
            end
            lsf_pkg::CFG_FRAME_HEIGHT:
            begin
                height_reg = data;
                row_pos    = 0;
                col_pos    = 0;
            end
            lsf_pkg::CFG_KERNEL_SELECT:
                sharpen_reg = data[0];
            default:
                ;
        endcase
    endfunction

    function automatic void filter_pixel(input logic [lsf_pkg::PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        int          acc;
        int          n;
        logic [lsf_pkg::PIX_W-1:0] up1;
        logic [lsf_pkg::PIX_W-1:0] up2;
        logic [lsf_pkg::PIX_W-1:0] v;
        pix_result_t res [3];
        w   = clip_size(width_reg);
        h   = clip_size(height_reg);
        r   = row_pos;
        c   = col_pos;
        idx = c % MAX_SIDE;
        up1 = row_above[idx];
        up2 = row_above2[idx];
        n   = 0;
        if (r >= 1 && c >= 1)
        begin
            if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
            begin
                acc = int'(window[1]) * (sharpen_reg ? 5 : 4) - int'(window[0])
                    - int'(window[4]) - int'(up1) - int'(window[2]);
                if (acc < 0)
                    acc = 0;
                else if (acc > 255)
                    acc = 255;
                v = lsf_pkg::PIX_W'(acc);
            end
            else
                v = window[1];
            res[n] = '{row: lsf_pkg::COORD_W'(r - 1), col: lsf_pkg::COORD_W'(c - 1),
                       value: v, last: 1'b0};
            n++;
        end
        if (r >= 1 && c + 1 >= w)
        begin
            res[n] = '{row: lsf_pkg::COORD_W'(r - 1), col: lsf_pkg::COORD_W'(c),
                       value: up1, last: 1'b0};
            n++;
        end
        if (r + 1 >= h)
        begin
            res[n] = '{row: lsf_pkg::COORD_W'(r), col: lsf_pkg::COORD_W'(c),
                       value: px, last: 1'b0};
            n++;
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            pending_px.push_back(res[i]);

        // advance window by one column
        window[3] = window[0];
        window[4] = window[1];
        window[5] = window[2];
        window[0] = up2;
        window[1] = up1;
        window[2] = px;
        row_above2[idx] = up1;
        row_above[idx]  = px;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endfunction

    task automatic note_fault(input string msg);
        if (faults < 10)
            $display("[%0t] %s", $realtime, msg);
        faults++;
    endtask

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic push_pixel(input logic [lsf_pkg::PIX_W-1:0] v);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 14)
                gap++;
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pixel_in  <= v;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        filter_pixel(v);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            push_pixel(lsf_pkg::PIX_W'($urandom_range(255)));
    endtask

    task automatic drain();
        pix_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [lsf_pkg::CIDX_W-1:0] idx,
                                  input logic [lsf_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        set_register(idx, data);
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [lsf_pkg::CFG_W-1:0] w,
                             input logic [lsf_pkg::CFG_W-1:0] h,
                             input logic sharpen);
        write_register(lsf_pkg::CFG_FRAME_WIDTH, w);
        write_register(lsf_pkg::CFG_FRAME_HEIGHT, h);
        write_register(lsf_pkg::CFG_KERNEL_SELECT, {{(lsf_pkg::CFG_W-1){1'b0}}, sharpen});
    endtask

    // reset geometry, checkerboard drives clamping at both ends
    task automatic test_reset_defaults();
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 5; c++)
                push_pixel(((r + c) % 2) ? 8'hFF : 8'h00);
        drain();
    endtask

    task automatic test_sharpen();
        calm = 1'b1;
        set_frame(11'd6, 11'd5, 1'b1);
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 6; c++)
                push_pixel((r < 2) ? (((r + c) % 2) ? 8'hFF : 8'h00)
                                   : lsf_pkg::PIX_W'($urandom_range(255)));
        drain();
        calm = 1'b0;
    endtask

    task automatic test_small_frames();
        int w;
        int h;
        for (int i = 0; i < 8; i++)
        begin
            set_frame(lsf_pkg::CFG_W'(SMALL_W[i]), lsf_pkg::CFG_W'(SMALL_H[i]),
                      1'($urandom_range(1)));
            w = clip_size(lsf_pkg::CFG_W'(SMALL_W[i]));
            h = clip_size(lsf_pkg::CFG_W'(SMALL_H[i]));
            push_random(2 * w * h);
            drain();
        end
    endtask

    task automatic test_restart();
        set_frame(11'd4, 11'd4, 1'b0);
        push_random(6);
        drain();
        write_register(CFG_UNUSED, lsf_pkg::CFG_W'($urandom_range(2047)));
        push_random(6);
        drain();
        write_register(lsf_pkg::CFG_FRAME_HEIGHT, 11'd4);
        push_random(8);
        drain();
        write_register(lsf_pkg::CFG_KERNEL_SELECT, 11'd1);
        push_random(8);
        drain();
        write_register(lsf_pkg::CFG_FRAME_WIDTH, 11'd5);
        push_random(20);
        drain();
    endtask

    task automatic test_random_frames();
        int sent;
        int w;
        int h;
        int n;
        logic [lsf_pkg::CFG_W-1:0] w_cfg;
        logic [lsf_pkg::CFG_W-1:0] h_cfg;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w_cfg = lsf_pkg::CFG_W'($urandom_range(0, 9));
            h_cfg = lsf_pkg::CFG_W'($urandom_range(0, 7));
            set_frame(w_cfg, h_cfg, 1'($urandom_range(1)));
            w = clip_size(w_cfg);
            h = clip_size(h_cfg);
            if ($urandom_range(9) < 8)
                n = $urandom_range(1, 2) * w * h;
            else
                n = $urandom_range(1, w * h);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            push_random(n);
            sent += n;
            drain();
        end
    endtask

    task automatic test_oversize();
        set_frame(11'd2047, 11'd1, 1'($urandom_range(1)));
        push_random(6);
        drain();
        set_frame(11'd1, 11'd2047, 1'($urandom_range(1)));
        push_random(6);
        drain();
    endtask

    always @(negedge clk)
        res_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);

    always @(posedge clk)
    begin : result_check
        pix_result_t want;
        if (rst_n && res_valid && res_ready)
        begin
            results_seen++;
            if (pending_px.size() == 0)
                note_fault($sformatf("unexpected word row %0d col %0d value %0d last %0b",
                                     out_row, out_col, out_value, run_last));
            else
            begin
                want = pending_px.pop_front();
                if (want.row !== out_row || want.col !== out_col ||
                    want.value !== out_value || want.last !== run_last)
                    note_fault($sformatf(
                        "mismatch: expected r%0d c%0d v%0d l%0b, got r%0d c%0d v%0d l%0b",
                        want.row, want.col, want.value, want.last,
                        out_row, out_col, out_value, run_last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_px.size());
            $display("** laplacian_sharpen_3x3_filter: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        pixel_in     = '0;
        res_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        cycles       = 0;
        faults       = 0;
        pixels_sent  = 0;
        results_seen = 0;
        reset_model();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_sharpen();
        test_small_frames();
        test_restart();
        test_random_frames();
        test_oversize();

        drain();
        if (pending_px.size() != 0)
            note_fault($sformatf("%0d expected words never arrived", pending_px.size()));

        $display("%0d pixels in, %0d result words checked, %0d failures", pixels_sent,
                 results_seen, faults);
        $display("both kernels, frames from 1x1 up, zero and oversize sizes, restarts");
        if (faults == 0)
            $display("** laplacian_sharpen_3x3_filter: PASSED **");
        else
            $display("** laplacian_sharpen_3x3_filter: FAILED **");
        $finish;
    end

endmodule

/* laplacian_sharpen_3x3_filter.f */
design/lsf_pkg.sv
design/lsf_line_mem.sv
design/lsf_pos_ctr.sv
design/lsf_emit.sv
design/laplacian_sharpen_3x3_filter.sv
dv/laplacian_sharpen_3x3_filter_test.sv
